// ===== rtl/cclp_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked command line parser package
// Shared types, character codes, default sizes and the CRC and hex helpers.
// ----------------------------------------------------------------------------
package cclp_pkg;

	// Default sizes handed to the top level parameters.
	localparam int LINE_BYTES_DEF = 64;
	localparam int MAX_TOKENS_DEF = 8;

	// Field widths of one result transaction.
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 6;
	localparam int TOK_W    = 4;
	localparam int CRC_W    = 16;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 56;

	// Character codes.
	localparam logic [7:0] CHR_BS    = 8'h08;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_VT    = 8'h0B;
	localparam logic [7:0] CHR_FF    = 8'h0C;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_COMMA = 8'h2C;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_SEMI  = 8'h3B;
	localparam logic [7:0] CHR_UX    = 8'h58;
	localparam logic [7:0] CHR_LX    = 8'h78;

	// CRC-16/MODBUS constants.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		STATUS_NO_CRC = 2'd0,
		STATUS_CRC_OK = 2'd1,
		STATUS_CRC_BAD = 2'd2
	} cclp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} cclp_state_t;

	typedef enum logic [2:0] {
		H_WS,
		H_PRE,
		H_ZERO,
		H_ZX,
		H_DIG,
		H_DONE
	} cclp_hex_phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;
		logic pop;
		logic scan_start;
		logic scan_step;
		logic load_out;
	} cclp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_eol;
		logic is_bs;
		logic empty;
		logic full;
		logic scan_done;
	} cclp_sts_t;

	// One byte of the reflected CRC-16, bit by bit.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Returns a valid flag above the four-bit value of a hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/cclp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Checked command line parser controller
// Sequences byte intake, the line walk and the hand-over of each result.
// ----------------------------------------------------------------------------
module cclp_ctrl import cclp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  cclp_sts_t sts,
	output cclp_cmd_t cmd
);

	cclp_state_t state_q;
	cclp_state_t state_d;
	logic        out_valid_q;
	logic        in_acc;
	logic        out_free;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && sts.is_eol && !sts.empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (sts.is_bs && !sts.empty) begin
						cmd.pop = 1'b1;
					end else if (sts.is_eol) begin
						cmd.scan_start = !sts.empty;
					end else if (!sts.full) begin
						cmd.push = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.load_out || (out_valid_q && !m_tready);
		end
	end

	// A pending result is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_out && out_valid_q && !m_tready))
		else $error("result overwritten while still pending");

	// A new result only appears out of the finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finishing state");

	// Starting a walk always moves the controller into the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> state_q == ST_SCAN)
		else $error("line walk started without entering the scan");

endmodule

// ===== rtl/cclp_dp.sv =====
// ----------------------------------------------------------------------------
// Checked command line parser datapath
// Line store, fill count, the byte-serial line walk and the result register.
// ----------------------------------------------------------------------------
module cclp_dp import cclp_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  rx_byte,
	input  cclp_cmd_t        cmd,
	output cclp_sts_t        sts,
	output logic [OUT_W-1:0] result
);

	localparam int AW    = $clog2(LINE_BYTES);
	localparam int DEPTH = LINE_BYTES - 1;
	localparam int TW    = $clog2(MAX_TOKENS + 1);

	logic [7:0]      mem [DEPTH];
	logic [AW-1:0]   fill_q;
	logic [AW-1:0]   rd_addr_q;
	logic [7:0]      rdata_s1;
	logic [AW-1:0]   rd_idx_s1;
	logic            rvalid_s1;

	logic [15:0]     crc_q;
	logic            seen_colon_q;
	logic            seen_semi_q;
	logic            in_params_q;
	logic            in_tok_q;
	logic [TW-1:0]   tokens_q;
	logic [AW-1:0]   colon_pos_q;
	cclp_hex_phase_t hex_phase_q;
	logic [15:0]     hex_val_q;
	logic            hex_neg_q;

	cclp_hex_phase_t hex_phase_d;
	cclp_hex_phase_t pre_phase;
	logic [15:0]     hex_val_d;
	logic            hex_neg_d;
	logic [4:0]      dig;
	logic            is_ws;
	logic [15:0]     rcv_crc;
	cclp_status_t    status;

	logic [STATUS_W-1:0] out_status_q;
	logic [LEN_W-1:0]    out_line_q;
	logic [LEN_W-1:0]    out_cmd_q;
	logic [TOK_W-1:0]    out_tok_q;
	logic [CRC_W-1:0]    out_crc_q;
	logic [CRC_W-1:0]    out_rcv_q;

	assign sts.is_eol    = (rx_byte == CHR_LF) || (rx_byte == CHR_CR);
	assign sts.is_bs     = (rx_byte == CHR_BS);
	assign sts.empty     = (fill_q == '0);
	assign sts.full      = (fill_q == AW'(DEPTH));
	assign sts.scan_done = (rd_addr_q == fill_q) && !rvalid_s1;

	// Line store: one write port for intake, one registered read for the walk.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[fill_q] <= rx_byte;
		end
		rdata_s1  <= mem[rd_addr_q];
		rd_idx_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_addr_q <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.pop) begin
				fill_q <= fill_q - 1'b1;
			end else if (cmd.load_out) begin
				fill_q <= '0;
			end
			if (cmd.scan_start) begin
				rd_addr_q <= '0;
				rvalid_s1 <= 1'b0;
			end else if (cmd.scan_step && rd_addr_q != fill_q) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				rvalid_s1 <= 1'b1;
			end else if (cmd.load_out) begin
				// The line is cleared, so the walk address returns to the start.
				rd_addr_q <= '0;
				rvalid_s1 <= 1'b0;
			end else begin
				rvalid_s1 <= 1'b0;
			end
		end
	end

	// Hex number after the first semicolon, one byte per step.
	always_comb begin
		dig   = hex_digit(rdata_s1);
		is_ws = (rdata_s1 == CHR_SPACE) || (rdata_s1 == CHR_TAB) ||
			(rdata_s1 == CHR_VT) || (rdata_s1 == CHR_FF);
		if (rdata_s1 == CHR_ZERO) begin
			pre_phase = H_ZERO;
		end else if (dig[4]) begin
			pre_phase = H_DIG;
		end else begin
			pre_phase = H_DONE;
		end
		hex_phase_d = hex_phase_q;
		hex_val_d   = hex_val_q;
		hex_neg_d   = hex_neg_q;
		case (hex_phase_q)
			H_WS: begin
				if (is_ws) begin
					hex_phase_d = H_WS;
				end else if (rdata_s1 == CHR_PLUS) begin
					hex_phase_d = H_PRE;
				end else if (rdata_s1 == CHR_MINUS) begin
					hex_phase_d = H_PRE;
					hex_neg_d   = 1'b1;
				end else begin
					hex_phase_d = pre_phase;
					if (dig[4]) begin
						hex_val_d = 16'(dig[3:0]);
					end
				end
			end
			H_PRE: begin
				hex_phase_d = pre_phase;
				if (dig[4]) begin
					hex_val_d = 16'(dig[3:0]);
				end
			end
			H_ZERO: begin
				if (rdata_s1 == CHR_LX || rdata_s1 == CHR_UX) begin
					hex_phase_d = H_ZX;
				end else if (dig[4]) begin
					hex_phase_d = H_DIG;
					hex_val_d   = {hex_val_q[11:0], dig[3:0]};
				end else begin
					hex_phase_d = H_DONE;
				end
			end
			H_ZX: begin
				if (dig[4]) begin
					hex_phase_d = H_DIG;
					hex_val_d   = 16'(dig[3:0]);
				end else begin
					hex_phase_d = H_DONE;
				end
			end
			H_DIG: begin
				if (dig[4]) begin
					hex_val_d = {hex_val_q[11:0], dig[3:0]};
				end else begin
					hex_phase_d = H_DONE;
				end
			end
			H_DONE: begin
				hex_phase_d = H_DONE;
			end
			default: hex_phase_d = H_DONE;
		endcase
	end

	// Walk accumulators: CRC, colon position, tokens and the hex field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			seen_colon_q <= 1'b0;
			seen_semi_q  <= 1'b0;
			in_params_q  <= 1'b0;
			in_tok_q     <= 1'b0;
			tokens_q     <= '0;
			colon_pos_q  <= '0;
			hex_phase_q  <= H_WS;
			hex_val_q    <= '0;
			hex_neg_q    <= 1'b0;
		end else if (cmd.scan_start) begin
			crc_q        <= CRC_INIT;
			seen_colon_q <= 1'b0;
			seen_semi_q  <= 1'b0;
			in_params_q  <= 1'b0;
			in_tok_q     <= 1'b0;
			tokens_q     <= '0;
			colon_pos_q  <= '0;
			hex_phase_q  <= H_WS;
			hex_val_q    <= '0;
			hex_neg_q    <= 1'b0;
		end else if (rvalid_s1) begin
			if (rdata_s1 == CHR_COLON && !seen_colon_q) begin
				seen_colon_q <= 1'b1;
				colon_pos_q  <= rd_idx_s1;
			end
			if (!seen_semi_q) begin
				if (rdata_s1 == CHR_SEMI) begin
					seen_semi_q <= 1'b1;
					in_params_q <= 1'b0;
				end else begin
					crc_q <= crc16_byte(crc_q, rdata_s1);
					if (rdata_s1 == CHR_COLON && !seen_colon_q) begin
						in_params_q <= 1'b1;
					end else if (in_params_q) begin
						if (rdata_s1 == CHR_COMMA) begin
							in_tok_q <= 1'b0;
						end else if (!in_tok_q) begin
							in_tok_q <= 1'b1;
							if (tokens_q != TW'(MAX_TOKENS)) begin
								tokens_q <= tokens_q + 1'b1;
							end
						end
					end
				end
			end else begin
				hex_phase_q <= hex_phase_d;
				hex_val_q   <= hex_val_d;
				hex_neg_q   <= hex_neg_d;
			end
		end
	end

	assign rcv_crc = hex_neg_q ? (16'd0 - hex_val_q) : hex_val_q;

	always_comb begin
		if (!seen_semi_q) begin
			status = STATUS_NO_CRC;
		end else if (crc_q == rcv_crc) begin
			status = STATUS_CRC_OK;
		end else begin
			status = STATUS_CRC_BAD;
		end
	end

	// Result register, held until the downstream side takes it.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status;
			out_line_q   <= LEN_W'(fill_q);
			out_cmd_q    <= seen_colon_q ? LEN_W'(colon_pos_q) : LEN_W'(fill_q);
			out_tok_q    <= TOK_W'(tokens_q);
			out_crc_q    <= crc_q;
			out_rcv_q    <= rcv_crc;
		end
	end

	assign result = {6'b0, out_rcv_q, out_crc_q, out_tok_q, out_cmd_q, out_line_q,
		out_status_q};

	// The fill count never passes the line store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= AW'(DEPTH))
		else $error("fill count beyond line store depth");

	// The walk never reads past the bytes held.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_addr_q <= fill_q)
		else $error("walk address beyond fill count");

	// Every byte processed by the walk lies within the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> rd_idx_s1 < fill_q)
		else $error("walk processed a byte outside the line");

endmodule

// ===== rtl/checked_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// Checked command line parser
// Collects received bytes into a line and, at each non-empty line end, reports
// the lengths, parameter token count and CRC-16/MODBUS check of the line.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents
// s_*       in         8      rx_byte, one received character per transaction
// m_*       out        56     one result per non-empty line
//
// An ordinary byte, a backspace or an end of line on an empty line is handled
// in the accepting cycle. An end of line on a non-empty line starts the walk:
// one registered read per byte, the last byte leaving the read register and
// the done check, then the result register is loaded once the output is free.
// Each walked byte before the first semicolon updates the CRC and token state;
// each byte after it updates the hex state.
// Reset clears the fill count, the controller and the result valid; the line
// store itself is not cleared, as only written bytes are ever read.
// Input is not taken during the walk, nor while a finished result waits behind
// an earlier one that has not been taken; a single pending result does not
// stall intake of the next line.
//
module checked_command_line_parser import cclp_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	// [1:0] frame_status, [7:2] line_length, [13:8] command_length,
	// [17:14] token_count, [33:18] computed_crc, [49:34] received_crc,
	// [55:50] zero
	output logic [OUT_W-1:0] m_tdata
);

	cclp_cmd_t cmd;
	cclp_sts_t sts;

	// The controller decides what each accepted transaction does and steps the
	// walk; the datapath holds the line and does all the byte arithmetic.
	cclp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cclp_dp #(
		.LINE_BYTES (LINE_BYTES),
		.MAX_TOKENS (MAX_TOKENS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.result  (m_tdata)
	);

endmodule
